// ===== src/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types, constants and round functions of the SHA-256 block compressor.
// ----------------------------------------------------------------------------
package sbc_pkg;

  typedef struct packed {
    logic [31:0] msg_word;
    logic        restart;
    logic        first;
    logic        last;
  } sbc_entry_t;

  typedef struct packed {
    logic       valid;
    sbc_entry_t entry;
  } sbc_push_t;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] v);
    big_sig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] v);
    big_sig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] v);
    small_sig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] v);
    small_sig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

// ===== src/sbc_if.sv =====
// ----------------------------------------------------------------------------
// sbc_in_if / sbc_out_if
// Valid/ready channels for message words in and digest words out.
// ----------------------------------------------------------------------------
interface sbc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_word;
  logic        restart;

  modport source (output valid, output msg_word, output restart, input ready);
  modport sink (input valid, input msg_word, input restart, output ready);
endinterface

interface sbc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last,
                output ready);
endinterface

// ===== src/sbc_front.sv =====
// ----------------------------------------------------------------------------
// sbc_front
// Accepts message words and tags the first and last word of each 16-word block.
// ----------------------------------------------------------------------------
module sbc_front
  import sbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  sbc_in_if.sink    in_if,
  input  logic      q_full,
  output sbc_push_t push
);

  logic [3:0] word_pos_r;
  logic       first;

  assign first        = (word_pos_r == 4'd0);
  assign in_if.ready  = !q_full;

  always_comb begin
    push.valid          = in_if.valid && !q_full;
    push.entry.msg_word = in_if.msg_word;
    push.entry.restart  = in_if.restart && first;
    push.entry.first    = first;
    push.entry.last     = (word_pos_r == 4'hf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_pos_r <= 4'd0;
    end else if (push.valid) begin
      word_pos_r <= word_pos_r + 4'd1;
    end
  end

endmodule

// ===== src/sbc_queue.sv =====
// ----------------------------------------------------------------------------
// sbc_queue
// Small FIFO of tagged message words between the front and the round engine.
// ----------------------------------------------------------------------------
module sbc_queue
  import sbc_pkg::*;
#(
  parameter int DEPTH = 4
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  sbc_push_t push,
  output logic      full,
  output sbc_push_t head,
  input  logic      pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sbc_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

endmodule

// ===== src/sbc_back.sv =====
// ----------------------------------------------------------------------------
// sbc_back
// Collects a block, runs the 64 rounds, adds the chaining value and emits it.
// ----------------------------------------------------------------------------
module sbc_back
  import sbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  sbc_push_t head,
  output logic      pop,
  sbc_out_if.source out_if
);

  typedef enum logic [3:0] {
    ST_COLLECT = 4'b0001,
    ST_ROUND   = 4'b0010,
    ST_ADD     = 4'b0100,
    ST_EMIT    = 4'b1000
  } state_t;

  state_t      state_r;
  state_t      state_nxt;
  logic [5:0]  round_r;
  logic [2:0]  emit_idx_r;
  logic        restart_r;
  logic [31:0] w_r     [16];
  logic [31:0] v_r     [8];
  logic [31:0] chain_r [8];

  logic        take;
  logic        block_done;
  logic        out_take;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  assign pop        = (state_r == ST_COLLECT);
  assign take       = pop && head.valid;
  assign block_done = take && head.entry.last;
  assign out_take   = out_if.valid && out_if.ready;

  assign out_if.valid       = (state_r == ST_EMIT);
  assign out_if.digest_word = chain_r[emit_idx_r];
  assign out_if.word_index  = emit_idx_r;
  assign out_if.last        = (emit_idx_r == 3'd7);

  always_comb begin
    ch    = v_r[6] ^ (v_r[4] & (v_r[5] ^ v_r[6]));
    maj   = (v_r[0] & v_r[1]) | (v_r[2] & (v_r[0] | v_r[1]));
    t1    = v_r[7] + big_sig1(v_r[4]) + ch + RoundConst[round_r] + w_r[0];
    t2    = big_sig0(v_r[0]) + maj;
    w_new = w_r[0] + small_sig0(w_r[1]) + w_r[9] + small_sig1(w_r[14]);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (block_done) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_r == 6'd63) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_take && out_if.last) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_COLLECT;
      round_r    <= 6'd0;
      emit_idx_r <= 3'd0;
      restart_r  <= 1'b0;
      for (int j = 0; j < 8; j++) begin
        chain_r[j] <= InitHash[j];
      end
    end else begin
      state_r <= state_nxt;
      if (take && head.entry.first) begin
        restart_r <= head.entry.restart;
      end
      if (block_done && restart_r) begin
        for (int j = 0; j < 8; j++) begin
          chain_r[j] <= InitHash[j];
        end
      end
      if (state_r == ST_ROUND) begin
        round_r <= round_r + 6'd1;
      end
      if (state_r == ST_ADD) begin
        for (int j = 0; j < 8; j++) begin
          chain_r[j] <= chain_r[j] + v_r[j];
        end
      end
      if (out_take) begin
        emit_idx_r <= emit_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int j = 0; j < 15; j++) begin
        w_r[j] <= w_r[j + 1];
      end
      w_r[15] <= head.entry.msg_word;
    end else if (state_r == ST_ROUND) begin
      for (int j = 0; j < 15; j++) begin
        w_r[j] <= w_r[j + 1];
      end
      w_r[15] <= w_new;
    end

    if (block_done) begin
      for (int j = 0; j < 8; j++) begin
        v_r[j] <= restart_r ? InitHash[j] : chain_r[j];
      end
    end else if (state_r == ST_ROUND) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

endmodule

// ===== src/sha256_block_compress_top.sv =====
// ----------------------------------------------------------------------------
// sha256_block_compress_top
// SHA-256 compression of a pre-padded stream of 32-bit message words.
// ----------------------------------------------------------------------------
// Each item in is one big-endian message word; sixteen items form a block, and
// restart on a block's first item loads the standard initial hash value first.
// After each block the eight updated chaining words come out as eight items,
// a first and h last, the last one flagged. A block's words are pulled from
// the input queue, run through the rounds in the single round unit and the
// feed-forward add, and then the digest is delivered; the next block is not
// pulled until the last digest item is taken. The input queue of QUEUE_DEPTH
// words takes items until it is full while a block is compressed or delivered.
module sha256_block_compress_top
  import sbc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
)
(
  input  logic      clk,
  input  logic      rst_n,
  sbc_in_if.sink    in_if,
  sbc_out_if.source out_if
);

  sbc_push_t push;
  sbc_push_t head;
  logic      q_full;
  logic      pop;

  sbc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_full (q_full),
    .push   (push)
  );

  sbc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  sbc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule

// ===== src/sbc_checker.sv =====
// ----------------------------------------------------------------------------
// sbc_checker
// Port-level checks on the digest channel of the block compressor.
// ----------------------------------------------------------------------------
module sbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last
);

  logic out_take;

  assign out_take = out_valid && out_ready;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_index))
    else $error("digest item changed while stalled");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_word_index == 3'd7)))
    else $error("last flag does not match the eighth word");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && !out_last |=> out_valid && (out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest words not delivered in order");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && out_last |=> !out_valid)
    else $error("digest item follows the last word directly");

  a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_word_index == 3'd0))
    else $error("digest does not start at word a");

endmodule

bind sha256_block_compress_top sbc_checker u_sbc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_digest_word (out_if.digest_word),
  .out_word_index  (out_if.word_index),
  .out_last        (out_if.last)
);
